>>> hdl/gic_pkg.sv
package gic_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_LEFT_DZ   = 2'd0;
	localparam logic [1:0] REG_RIGHT_DZ  = 2'd1;
	localparam logic [1:0] REG_PRESS_LVL = 2'd2;
	localparam logic [1:0] REG_HOLD_LVL  = 2'd3;

	localparam logic [14:0] LEFT_DZ_RST   = 15'd7849;
	localparam logic [14:0] RIGHT_DZ_RST  = 15'd8689;
	localparam logic [7:0]  PRESS_LVL_RST = 8'd30;
	localparam logic [7:0]  HOLD_LVL_RST  = 8'd250;

	localparam logic [15:0] DIR_MAX = 16'h7FFF;

	// digit-recurrence sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_LOAD,
		ST_DIV,
		ST_NEXT,
		ST_DONE
	} state_t;

endpackage

>>> hdl/gamepad_input_conditioner_core.sv
// Channel | signals                               | transfer when
// in      | in_valid / in_ready, poll fields       | in_valid & in_ready
// out     | out_valid / out_ready, result fields   | out_valid & out_ready
// cfg     | cfg_we, cfg_index, cfg_data           | cfg_we
//
// One poll at a time. Each direction component is q = floor(sqrt(a^2*2^30/s)),
// found over 16 quotient bits, each in three phases: c*c, (c*c)*s plus compare, step.
// Squares x^2, y^2, dz^2, a^2 are formed by the shift-add multiplier.
// arst_n clears all control and the stored buttons/triggers. A stalled result
// holds in the output registers; in_ready stays low until it is taken.
module gamepad_input_conditioner_core
	import gic_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               connected,
	input  logic [15:0]        buttons,
	input  logic [7:0]         left_trigger,
	input  logic [7:0]         right_trigger,
	input  logic signed [15:0] left_x,
	input  logic signed [15:0] left_y,
	input  logic signed [15:0] right_x,
	input  logic signed [15:0] right_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        button_level,
	output logic [15:0]        button_pressed,
	output logic               left_trigger_held,
	output logic               right_trigger_held,
	output logic               left_trigger_pressed,
	output logic               right_trigger_pressed,
	output logic signed [15:0] left_dir_x,
	output logic signed [15:0] left_dir_y,
	output logic signed [15:0] right_dir_x,
	output logic signed [15:0] right_dir_y
);

	// configuration registers
	logic [14:0] left_dz_q, right_dz_q;
	logic [7:0]  press_lvl_q, hold_lvl_q;
	logic [15:0] last_btn_q;
	logic [7:0]  last_lt_q, last_rt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dz_q   <= LEFT_DZ_RST;
			right_dz_q  <= RIGHT_DZ_RST;
			press_lvl_q <= PRESS_LVL_RST;
			hold_lvl_q  <= HOLD_LVL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEFT_DZ:   left_dz_q   <= cfg_data;
				REG_RIGHT_DZ:  right_dz_q  <= cfg_data;
				REG_PRESS_LVL: press_lvl_q <= cfg_data[7:0];
				REG_HOLD_LVL:  hold_lvl_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// captured stick words, gated by connected
	logic [15:0] ax_q [4];
	logic [3:0]  neg_q;
	logic [15:0] dir_q [4];

	state_t      state_q, state_d;
	logic [1:0]  comp_q;        // component 0..3 (lx, ly, rx, ry)
	logic [3:0]  bit_q;         // quotient bit position
	logic [15:0] q_q;
	logic [32:0] s_q;           // x^2 + y^2 of current stick
	logic        live_q;        // outside deadzone
	logic [5:0]  mcnt_q;        // shift-add step
	logic [1:0]  mph_q;         // multiply phase
	logic [63:0] acc_q;         // shift-add accumulator
	logic [63:0] mcand_q;
	logic [32:0] mplr_q;
	logic [31:0] cc_q;          // c*c
	logic [31:0] aa_q;          // a*a
	logic [15:0] cand;

	logic [15:0] a_cur;
	assign a_cur = ax_q[comp_q];
	assign cand  = q_q | (16'd1 << bit_q);
	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid && in_ready) state_d = ST_SQUARE;
			ST_SQUARE: if (mph_q == 2'd3 && mcnt_q == 6'd32) state_d = ST_LOAD;
			ST_LOAD:   state_d = live_q ? ST_DIV : ST_NEXT;
			ST_DIV:    if (mph_q == 2'd2 && mcnt_q == 6'd33 && bit_q == 4'd0)
				state_d = ST_NEXT;
			ST_NEXT:   state_d = (comp_q == 2'd3) ? ST_DONE : ST_SQUARE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// shift-add multiply: acc += mcand if mplr lsb, one bit a cycle
	logic [63:0] acc_next;
	assign acc_next = acc_q + (mplr_q[0] ? mcand_q : 64'd0);

	logic [15:0] sx, sy;
	assign sx = ax_q[{comp_q[1], 1'b0}];
	assign sy = ax_q[{comp_q[1], 1'b1}];

	// datapath sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q  <= '0;
			mph_q   <= '0;
			mcnt_q  <= '0;
			bit_q   <= '0;
			live_q  <= 1'b0;
			q_q     <= '0;
			s_q     <= '0;
			acc_q   <= '0;
			mcand_q <= '0;
			mplr_q  <= '0;
			cc_q    <= '0;
			aa_q    <= '0;
			dir_q   <= '{default: '0};
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					comp_q <= '0;
					mph_q  <= '0;
					mcnt_q <= '0;
				end
				ST_SQUARE: begin
					// phases: 0 x^2, 1 y^2, 2 dz^2, 3 a^2
					if (mcnt_q == 6'd0) begin
						acc_q <= '0;
						unique case (mph_q)
							2'd0: begin mcand_q <= {48'd0, sx}; mplr_q <= {17'd0, sx}; end
							2'd1: begin mcand_q <= {48'd0, sy}; mplr_q <= {17'd0, sy}; end
							2'd2: begin
								mcand_q <= {49'd0, comp_q[1] ? right_dz_q : left_dz_q};
								mplr_q  <= {18'd0, comp_q[1] ? right_dz_q : left_dz_q};
							end
							default: begin
								mcand_q <= {48'd0, a_cur}; mplr_q <= {17'd0, a_cur};
							end
						endcase
						mcnt_q <= 6'd1;
					end else if (mcnt_q != 6'd32) begin
						acc_q  <= acc_next;
						mcand_q <= mcand_q << 1;
						mplr_q <= mplr_q >> 1;
						mcnt_q <= mcnt_q + 6'd1;
					end else begin
						unique case (mph_q)
							2'd0: s_q <= {1'b0, acc_q[31:0]};
							2'd1: s_q <= s_q + {1'b0, acc_q[31:0]};
							2'd2: live_q <= s_q > {1'b0, acc_q[31:0]};
							default: aa_q <= acc_q[31:0];
						endcase
						mph_q  <= mph_q + 2'd1;
						mcnt_q <= '0;
					end
				end
				ST_LOAD: begin
					q_q    <= '0;
					bit_q  <= 4'd15;
					mph_q  <= '0;
					mcnt_q <= '0;
				end
				ST_DIV: begin
					// phase 0: c*c, phase 1: (c*c)*s and compare, phase 2: next bit
					if (mph_q == 2'd2) begin
						mph_q  <= '0;
						mcnt_q <= '0;
						bit_q  <= bit_q - 4'd1;
					end else if (mcnt_q == 6'd0) begin
						acc_q <= '0;
						if (mph_q == 2'd0) begin
							mcand_q <= {48'd0, cand}; mplr_q <= {17'd0, cand};
						end else begin
							mcand_q <= {32'd0, cc_q}; mplr_q <= s_q;
						end
						mcnt_q <= 6'd1;
					end else if (mcnt_q != 6'd34 && !(mph_q == 2'd0 && mcnt_q == 6'd17)) begin
						acc_q  <= acc_next;
						mcand_q <= mcand_q << 1;
						mplr_q <= mplr_q >> 1;
						mcnt_q <= mcnt_q + 6'd1;
					end else if (mph_q == 2'd0) begin
						cc_q   <= acc_q[31:0];
						mph_q  <= 2'd1;
						mcnt_q <= '0;
					end else begin
						mph_q  <= 2'd2;
						mcnt_q <= 6'd33;
						if (acc_q <= {2'd0, aa_q, 30'd0}) q_q <= cand;
					end
				end
				ST_NEXT: begin
					comp_q <= comp_q + 2'd1;
					if (comp_q[0]) live_q <= 1'b0;
					mph_q  <= comp_q[0] ? 2'd0 : 2'd3;
					mcnt_q <= '0;
					if (!live_q) dir_q[comp_q] <= '0;
					else if (neg_q[comp_q])
						dir_q[comp_q] <= 16'd0 - ((q_q > DIR_MAX) ? DIR_MAX : q_q);
					else dir_q[comp_q] <= (q_q > DIR_MAX) ? DIR_MAX : q_q;
				end
				default: ;
			endcase
		end
	end

	// input capture and trigger/button logic
	logic [15:0] btn_g;
	logic [7:0]  lt_g, rt_g;
	assign btn_g = connected ? buttons : '0;
	assign lt_g  = connected ? left_trigger : '0;
	assign rt_g  = connected ? right_trigger : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_btn_q            <= '0;
			last_lt_q             <= '0;
			last_rt_q             <= '0;
			out_valid             <= 1'b0;
			button_level          <= '0;
			button_pressed        <= '0;
			left_trigger_held     <= 1'b0;
			right_trigger_held    <= 1'b0;
			left_trigger_pressed  <= 1'b0;
			right_trigger_pressed <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				button_level          <= btn_g;
				button_pressed        <= btn_g & ~last_btn_q;
				left_trigger_held     <= lt_g > hold_lvl_q;
				right_trigger_held    <= rt_g > hold_lvl_q;
				left_trigger_pressed  <= connected && last_lt_q < press_lvl_q
					&& lt_g >= press_lvl_q;
				right_trigger_pressed <= connected && last_rt_q < press_lvl_q
					&& rt_g >= press_lvl_q;
				last_btn_q <= btn_g;
				last_lt_q  <= lt_g;
				last_rt_q  <= rt_g;
			end
			if (state_q == ST_DONE) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// magnitudes and signs of gated stick words
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ax_q[0] <= !connected ? '0 : left_x[15]  ? 16'd0 - left_x  : left_x;
			ax_q[1] <= !connected ? '0 : left_y[15]  ? 16'd0 - left_y  : left_y;
			ax_q[2] <= !connected ? '0 : right_x[15] ? 16'd0 - right_x : right_x;
			ax_q[3] <= !connected ? '0 : right_y[15] ? 16'd0 - right_y : right_y;
			neg_q   <= connected ? {right_y[15], right_x[15], left_y[15], left_x[15]} : '0;
		end
	end

	assign left_dir_x  = dir_q[0];
	assign left_dir_y  = dir_q[1];
	assign right_dir_x = dir_q[2];
	assign right_dir_y = dir_q[3];

	// result only appears once the sequencer finishes
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised without finished sequence");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input taken while busy");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEXT && !live_q) |=> dir_q[$past(comp_q)] == '0)
		else $error("deadzone component not zero");

endmodule

>>> tb/tb_top.sv
`default_nettype none

module tb_top
	import gic_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_OFF_CYCLES = 3000;
	localparam int STALL_LIMIT     = 30000;
	localparam int RANDOM_POLLS    = 1300;

	// one poll as driven, one conditioned result as predicted
	typedef struct {
		logic        connected;
		logic [15:0] buttons;
		logic [7:0]  lt, rt;
		logic [15:0] lx, ly, rx, ry;
	} poll_t;

	typedef struct {
		logic [15:0] level, pressed;
		logic        lt_held, rt_held, lt_pressed, rt_pressed;
		logic [15:0] ldx, ldy, rdx, rdy;
	} cond_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_LEFT_DZ;
	logic [14:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic connected = 1'b0;
	logic [15:0] buttons = '0;
	logic [7:0] left_trigger = '0, right_trigger = '0;
	logic signed [15:0] left_x = '0, left_y = '0, right_x = '0, right_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] button_level, button_pressed;
	logic left_trigger_held, right_trigger_held;
	logic left_trigger_pressed, right_trigger_pressed;
	logic signed [15:0] left_dir_x, left_dir_y, right_dir_x, right_dir_y;

	gamepad_input_conditioner_core dut (.*);

	// predictor copy of registers and history
	logic [14:0] dz_left, dz_right;
	logic [7:0]  press_lvl, hold_lvl;
	logic [15:0] prev_buttons;
	logic [7:0]  prev_lt, prev_rt;

	cond_t expected_results[$];
	int fail_count = 0;
	int polls_sent = 0;
	int results_seen = 0;
	bit hold_off = 1'b0;
	bit no_idle = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	// largest q with q*q*s <= a*a*2^30, saturated and signed
	function automatic logic [15:0] unit_component(logic [15:0] raw, bit [63:0] s);
		bit [63:0] a, target, q, c;
		a = raw[15] ? (64'h10000 - raw) : raw;
		target = (a * a) << 30;
		q = 0;
		for (int b = 15; b >= 0; b--) begin
			c = q | (64'd1 << b);
			if (c * c * s <= target)
				q = c;
		end
		if (q > DIR_MAX)
			q = DIR_MAX;
		return raw[15] ? 16'(-q) : 16'(q);
	endfunction

	task automatic stick_direction(input logic [15:0] x, input logic [15:0] y,
			input logic [14:0] dz, output logic [15:0] dx, output logic [15:0] dy);
		bit [63:0] ax, ay, s;
		ax = x[15] ? (64'h10000 - x) : x;
		ay = y[15] ? (64'h10000 - y) : y;
		s = ax * ax + ay * ay;
		if (s > 64'(dz) * 64'(dz)) begin
			dx = unit_component(x, s);
			dy = unit_component(y, s);
		end else begin
			dx = '0;
			dy = '0;
		end
	endtask

	task automatic condition_poll(input poll_t p);
		cond_t r;
		poll_t g;
		g = p;
		if (!p.connected) begin
			g.buttons = '0; g.lt = '0; g.rt = '0;
			g.lx = '0; g.ly = '0; g.rx = '0; g.ry = '0;
		end
		r.level = g.buttons;
		r.pressed = g.buttons & ~prev_buttons;
		r.lt_held = g.lt > hold_lvl;
		r.rt_held = g.rt > hold_lvl;
		r.lt_pressed = p.connected && prev_lt < press_lvl && g.lt >= press_lvl;
		r.rt_pressed = p.connected && prev_rt < press_lvl && g.rt >= press_lvl;
		stick_direction(g.lx, g.ly, dz_left, r.ldx, r.ldy);
		stick_direction(g.rx, g.ry, dz_right, r.rdx, r.rdy);
		prev_buttons = g.buttons;
		prev_lt = g.lt;
		prev_rt = g.rt;
		expected_results.push_back(r);
	endtask

	task automatic report_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] want);
		$display("MISMATCH result %0d %s: got %h expected %h", results_seen, field, got,
			want);
		fail_count++;
	endtask

	// one poll transfer, optional idle burst after it
	task automatic send_poll(input poll_t p);
		@(negedge clk);
		in_valid <= 1'b1;
		connected <= p.connected;
		buttons <= p.buttons;
		left_trigger <= p.lt;
		right_trigger <= p.rt;
		left_x <= p.lx;
		left_y <= p.ly;
		right_x <= p.rx;
		right_y <= p.ry;
		do @(posedge clk); while (!in_ready);
		condition_poll(p);
		polls_sent++;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12) - 1) @(negedge clk);
		end
	endtask

	task automatic make_poll(input logic c, input logic [15:0] b, input logic [7:0] lt,
			input logic [7:0] rt, input logic [15:0] lx, input logic [15:0] ly,
			input logic [15:0] rx, input logic [15:0] ry);
		poll_t p;
		p.connected = c; p.buttons = b; p.lt = lt; p.rt = rt;
		p.lx = lx; p.ly = ly; p.rx = rx; p.ry = ry;
		send_poll(p);
	endtask

	// stop offering before waiting, so the last poll is not taken twice
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LEFT_DZ:   dz_left = val;
			REG_RIGHT_DZ:  dz_right = val;
			REG_PRESS_LVL: press_lvl = val[7:0];
			default:       hold_lvl = val[7:0];
		endcase
	endtask

	task automatic write_all(input logic [14:0] l, input logic [14:0] r,
			input logic [14:0] pr, input logic [14:0] hl);
		drain_results();
		write_reg(REG_LEFT_DZ, l);
		write_reg(REG_RIGHT_DZ, r);
		write_reg(REG_PRESS_LVL, pr);
		write_reg(REG_HOLD_LVL, hl);
	endtask

	function automatic logic [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 12000)) - 16'd6000;
			3: return 16'($urandom_range(0, 20000)) - 16'd10000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] rand_trigger(input logic [7:0] lvl);
		case ($urandom_range(0, 3))
			0: return lvl + 8'($urandom_range(0, 4)) - 8'd2;
			1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_random_poll();
		poll_t p;
		p.connected = $urandom_range(0, 9) != 0;
		p.buttons = $urandom_range(0, 2) == 0 ? prev_buttons ^ 16'(1 << $urandom_range(0, 15))
			: 16'($urandom);
		p.lt = rand_trigger($urandom_range(0, 1) ? press_lvl : hold_lvl);
		p.rt = rand_trigger($urandom_range(0, 1) ? press_lvl : hold_lvl);
		p.lx = rand_axis(); p.ly = rand_axis();
		p.rx = rand_axis(); p.ry = rand_axis();
		send_poll(p);
	endtask

	// extremes of every field and the edge/deadzone special cases
	task automatic test_directed();
		make_poll(1, 16'hFFFF, 8'd255, 8'd255, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
		make_poll(1, 16'hFFFF, 8'd255, 8'd0, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF);
		make_poll(0, 16'hA5A5, 8'd200, 8'd200, 16'h7FFF, 16'h1234, 16'h8000, 16'h4321);
		make_poll(1, 16'h5A5A, 8'd30, 8'd29, 16'd0, 16'd0, 16'd0, 16'd0);
		make_poll(1, 16'hA5A5, 8'd251, 8'd250, 16'd7849, 16'd0, 16'd8689, 16'd0);
		make_poll(1, 16'h0000, 8'd0, 8'd30, 16'd7850, 16'd0, 16'd0, 16'd8690);
		make_poll(1, 16'hFFFF, 8'd29, 8'd0, -16'sd7850, -16'sd1, 16'h8000, 16'h7FFF);
		make_poll(1, 16'h0001, 8'd31, 8'd31, 16'd6000, 16'd6000, -16'sd6200, 16'd6200);
		make_poll(1, 16'h8000, 8'd0, 8'd0, 16'd1, 16'h8000, 16'h7FFF, 16'd1);
	endtask

	// every register, including the extremes of each
	task automatic test_register_extremes();
		write_all(15'd0, 15'h7FFF, 15'd0, 15'd255);
		make_poll(1, 16'h00FF, 8'd255, 8'd255, 16'd1, 16'd0, 16'h7FFF, 16'h7FFF);
		make_poll(1, 16'hFF00, 8'd0, 8'd0, 16'd0, 16'd0, 16'h8000, 16'h8000);
		make_poll(1, 16'hFFFF, 8'd255, 8'd1, -16'sd1, -16'sd1, 16'h8000, 16'd0);
		write_all(15'h7FFF, 15'd0, 15'd255, 15'd0);
		make_poll(1, 16'h1234, 8'd254, 8'd1, 16'h8000, 16'h8000, 16'd0, 16'd1);
		make_poll(1, 16'h4321, 8'd255, 8'd255, 16'h8000, 16'd0, 16'd0, 16'd0);
		make_poll(1, 16'h4321, 8'd0, 8'd0, 16'h7FFF, 16'd0, 16'h7FFF, 16'h8000);
		make_poll(1, 16'h0000, 8'd255, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		write_all(15'h7F00 | 15'd7849, 15'h7F00 | 15'd100, 15'h7F80, 15'h7F7F);
		make_poll(1, 16'hFFFF, 8'd128, 8'd127, 16'd100, 16'd0, 16'd101, 16'd0);
	endtask

	// several random register settings, random polls in each
	task automatic test_random_polls();
		for (int phase = 0; phase < 6; phase++) begin
			write_all($urandom_range(0, 1) ? 15'($urandom_range(0, 12000)) : 15'($urandom),
				$urandom_range(0, 1) ? 15'($urandom_range(0, 12000)) : 15'($urandom),
				15'($urandom), 15'($urandom));
			repeat (RANDOM_POLLS / 6) send_random_poll();
		end
	endtask

	// receiver holds off long while polls keep coming, so the input stalls
	task automatic test_output_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
		join_none
		repeat (30) send_random_poll();
	endtask

	// tail with no idling on either side
	task automatic test_full_rate();
		no_idle = 1'b1;
		repeat (60) send_random_poll();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// receiver idle bursts
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off)
				out_ready <= 1'b0;
			else if (!no_idle && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else
				out_ready <= 1'b1;
		end
	end

	// result check
	always @(posedge clk) begin
		cond_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("MISMATCH result %0d with no poll outstanding", results_seen);
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				if (button_level !== e.level) report_mismatch("button_level", button_level,
					e.level);
				if (button_pressed !== e.pressed) report_mismatch("button_pressed",
					button_pressed, e.pressed);
				if (left_trigger_held !== e.lt_held) report_mismatch("left_trigger_held",
					left_trigger_held, e.lt_held);
				if (right_trigger_held !== e.rt_held) report_mismatch("right_trigger_held",
					right_trigger_held, e.rt_held);
				if (left_trigger_pressed !== e.lt_pressed)
					report_mismatch("left_trigger_pressed", left_trigger_pressed, e.lt_pressed);
				if (right_trigger_pressed !== e.rt_pressed)
					report_mismatch("right_trigger_pressed", right_trigger_pressed,
						e.rt_pressed);
				if (left_dir_x !== e.ldx) report_mismatch("left_dir_x", left_dir_x, e.ldx);
				if (left_dir_y !== e.ldy) report_mismatch("left_dir_y", left_dir_y, e.ldy);
				if (right_dir_x !== e.rdx) report_mismatch("right_dir_x", right_dir_x, e.rdx);
				if (right_dir_y !== e.rdy) report_mismatch("right_dir_y", right_dir_y, e.rdy);
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", quiet);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		dz_left = LEFT_DZ_RST;
		dz_right = RIGHT_DZ_RST;
		press_lvl = PRESS_LVL_RST;
		hold_lvl = HOLD_LVL_RST;
		prev_buttons = '0;
		prev_lt = '0;
		prev_rt = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_register_extremes();
		test_random_polls();
		test_output_backpressure();
		test_full_rate();
		drain_results();

		$display("Covered %0d polls and %0d results over reset, extreme and random settings,",
			polls_sent, results_seen);
		$display("with idle bursts, a long output stall and a full-rate tail.");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
